// File: rtl/core/defet_pkg.sv
// ----------------------------------------------------------------------------
// defet_pkg
// Shared types and constants for the delayed event flag table.
// ----------------------------------------------------------------------------
package defet_pkg;

    localparam int EVENT_COUNT = 256;
    localparam int EVT_IDX_W   = $clog2(EVENT_COUNT);
    localparam int ID_W        = 16;
    localparam int TIME_W      = 32;
    localparam int BND_W       = 9;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 32;

    typedef enum logic [1:0] {
        FUNC_SET   = 2'd0,
        FUNC_CLEAR = 2'd1,
        FUNC_DSET  = 2'd2,
        FUNC_GET   = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LONG_DELAY  = 2'd0,
        CFG_SHORT_DELAY = 2'd1,
        CFG_SHORT_START = 2'd2,
        CFG_NODLY_START = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [TIME_W-1:0] long_delay;
        logic [TIME_W-1:0] short_delay;
        logic [BND_W-1:0]  short_start;
        logic [BND_W-1:0]  nodly_start;
    } t_cfg;

    typedef struct packed {
        logic              valid;
        t_func             func;
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] now;
    } t_op;

    typedef struct packed {
        logic delivered;
        logic in_range;
    } t_res;

    localparam logic [TIME_W-1:0] LONG_DELAY_RST  = TIME_W'(60000);
    localparam logic [TIME_W-1:0] SHORT_DELAY_RST = TIME_W'(10000);
    localparam logic [BND_W-1:0]  SHORT_START_RST = BND_W'(64);
    localparam logic [BND_W-1:0]  NODLY_START_RST = BND_W'(128);

endpackage

// File: rtl/core/defet_cfg_regs.sv
// ----------------------------------------------------------------------------
// defet_cfg_regs
// Configuration registers: delays and event number boundaries.
// ----------------------------------------------------------------------------
module defet_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [defet_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [defet_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output defet_pkg::t_cfg                     o_cfg
);
    import defet_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                CFG_LONG_DELAY:  n_cfg.long_delay  = i_cfg_data[TIME_W-1:0];
                CFG_SHORT_DELAY: n_cfg.short_delay = i_cfg_data[TIME_W-1:0];
                CFG_SHORT_START: n_cfg.short_start = i_cfg_data[BND_W-1:0];
                CFG_NODLY_START: n_cfg.nodly_start = i_cfg_data[BND_W-1:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.long_delay  <= LONG_DELAY_RST;
            r_cfg.short_delay <= SHORT_DELAY_RST;
            r_cfg.short_start <= SHORT_START_RST;
            r_cfg.nodly_start <= NODLY_START_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/core/defet_flag_table.sv
// ----------------------------------------------------------------------------
// defet_flag_table
// Pending and holdoff bits per event plus the shared delay stamp. Performs
// the read-modify-write of one operation in one step: a combinational read and a registered update.
// ----------------------------------------------------------------------------
module defet_flag_table (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  defet_pkg::t_cfg   i_cfg,
    input  defet_pkg::t_op    i_op,
    output defet_pkg::t_res   o_res
);
    import defet_pkg::*;

    logic [EVENT_COUNT-1:0] r_pending;
    logic [EVENT_COUNT-1:0] r_holdoff;
    logic [TIME_W-1:0]      r_stamp;

    logic [EVT_IDX_W-1:0]   idx;
    logic                   in_range;
    logic                   hit;
    logic                   ready;
    logic                   deliver;
    logic [TIME_W-1:0]      elapsed;
    logic                   below_short;
    logic                   below_nodly;

    assign in_range    = ({1'b0, i_op.id} < (ID_W + 1)'(EVENT_COUNT));
    assign idx         = i_op.id[EVT_IDX_W-1:0];
    assign hit         = i_op.valid && in_range;
    assign elapsed     = i_op.now - r_stamp;
    assign below_short = (i_op.id < ID_W'(i_cfg.short_start));
    assign below_nodly = (i_op.id < ID_W'(i_cfg.nodly_start));

    // The boundaries are tested in order, so they may be programmed in any order.
    always_comb begin
        if (!r_pending[idx]) begin
            ready = 1'b0;
        end else if (!r_holdoff[idx]) begin
            ready = 1'b1;
        end else if (below_short) begin
            ready = (elapsed > i_cfg.long_delay);
        end else if (below_nodly) begin
            ready = (elapsed > i_cfg.short_delay);
        end else begin
            ready = 1'b1;
        end
    end

    assign deliver = hit && (i_op.func == FUNC_GET) && ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
            r_holdoff <= '0;
            r_stamp   <= '0;
        end else if (hit) begin
            case (i_op.func)
                FUNC_SET: begin
                    r_pending[idx] <= 1'b1;
                end
                FUNC_CLEAR: begin
                    r_pending[idx] <= 1'b0;
                end
                FUNC_DSET: begin
                    r_pending[idx] <= 1'b1;
                    r_stamp        <= i_op.now;
                    if (below_nodly) begin
                        r_holdoff[idx] <= 1'b1;
                    end
                end
                default: begin
                    if (deliver) begin
                        r_pending[idx] <= 1'b0;
                        r_holdoff[idx] <= 1'b0;
                    end
                end
            endcase
        end
    end

    assign o_res.delivered = deliver;
    assign o_res.in_range  = in_range;

endmodule

// File: rtl/core/delayed_event_flag_table_unit.sv
// ----------------------------------------------------------------------------
// delayed_event_flag_table_unit
// Table of pending event flags with optional holdoff, one operation per item.
// ----------------------------------------------------------------------------
// The unit takes one item per clock cycle while o_in_stall is low and returns
// exactly one result per item. Each item goes into an input register; once the
// output register is free, the flag table reads and updates the two bits of
// the named event and the shared stamp in one step, and the result lands in
// the output register. Because the table update completes in that single
// step, consecutive items on the same event see each other's effects without
// any wait. Configuration writes take effect in the cycle after the write
// and should be made only while the unit is idle.
module delayed_event_flag_table_unit (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [defet_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [defet_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [1:0]                        i_func,
    input  logic [defet_pkg::ID_W-1:0]        i_event_id,
    input  logic [defet_pkg::TIME_W-1:0]      i_now_time,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_delivered,
    output logic                              o_in_range
);
    import defet_pkg::*;

    t_cfg  cfg;
    t_op   op;
    t_res  res;

    logic              r_in_valid;
    t_func             r_func;
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_now;
    logic              r_out_valid;
    logic              r_delivered;
    logic              r_in_range;

    logic              out_free;
    logic              advance;
    logic              in_xfer;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_xfer    = i_in_valid && !o_in_stall;

    defet_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // The table only acts on an item in the cycle it moves to the output.
    assign op.valid = advance;
    assign op.func  = r_func;
    assign op.id    = r_id;
    assign op.now   = r_now;

    defet_flag_table u_table (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_op    (op),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_func <= t_func'(i_func);
            r_id   <= i_event_id;
            r_now  <= i_now_time;
        end
        if (advance) begin
            r_delivered <= res.delivered;
            r_in_range  <= res.in_range;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_delivered = r_delivered;
    assign o_in_range  = r_in_range;

endmodule

// File: sim/delayed_event_flag_table_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// delayed_event_flag_table_unit_tb
// Self-checking bench for the delayed event flag table.
// ----------------------------------------------------------------------------
// A short directed sequence covers the boundaries, wrap of the elapsed time,
// clear versus holdoff and out-of-range events. It is followed by random
// phases under several register settings. A tracker object mirrors the flag
// table and checks each result in order. The sender works in bursts and the
// receiver stalls on its own changing pattern.
// ----------------------------------------------------------------------------
module delayed_event_flag_table_unit_tb;
    import defet_pkg::*;

    localparam int CLK_PERIOD     = 10;
    localparam int RESET_CYCLES   = 6;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    // Mirror of the flag table; holds the results still owed by the unit.
    class event_flag_tracker;
        bit                pending  [EVENT_COUNT];
        bit                holdoff  [EVENT_COUNT];
        logic [TIME_W-1:0] stamp;
        logic [TIME_W-1:0] long_delay;
        logic [TIME_W-1:0] short_delay;
        logic [BND_W-1:0]  short_start;
        logic [BND_W-1:0]  nodly_start;
        t_res              outcome_q [$];
        int                error_count;

        function new();
            stamp       = '0;
            long_delay  = LONG_DELAY_RST;
            short_delay = SHORT_DELAY_RST;
            short_start = SHORT_START_RST;
            nodly_start = NODLY_START_RST;
            error_count = 0;
        endfunction

        function void write_reg(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_LONG_DELAY:  long_delay  = data;
                CFG_SHORT_DELAY: short_delay = data;
                CFG_SHORT_START: short_start = data[BND_W-1:0];
                CFG_NODLY_START: nodly_start = data[BND_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_op(t_func f, logic [ID_W-1:0] id, logic [TIME_W-1:0] now);
            t_res              res;
            logic [TIME_W-1:0] elapsed;
            bit                ready;
            res = '0;
            if (id < EVENT_COUNT) begin
                res.in_range = 1'b1;
                case (f)
                    FUNC_SET:   pending[id] = 1'b1;
                    FUNC_CLEAR: pending[id] = 1'b0;
                    FUNC_DSET: begin
                        pending[id] = 1'b1;
                        stamp       = now;
                        if (id < nodly_start)
                            holdoff[id] = 1'b1;
                    end
                    default: begin
                        // The elapsed time wraps and must strictly exceed the delay.
                        elapsed = now - stamp;
                        if (!pending[id])
                            ready = 1'b0;
                        else if (!holdoff[id])
                            ready = 1'b1;
                        else if (id < short_start)
                            ready = elapsed > long_delay;
                        else if (id < nodly_start)
                            ready = elapsed > short_delay;
                        else
                            ready = 1'b1;
                        if (ready) begin
                            res.delivered = 1'b1;
                            pending[id]   = 1'b0;
                            holdoff[id]   = 1'b0;
                        end
                    end
                endcase
            end
            outcome_q.push_back(res);
        endfunction

        function void check_outcome(logic delivered, logic in_range);
            t_res exp_res;
            if (outcome_q.size() == 0) begin
                $error("unexpected result: delivered %0b, in_range %0b", delivered, in_range);
                error_count++;
                return;
            end
            exp_res = outcome_q.pop_front();
            if (delivered !== exp_res.delivered) begin
                $error("delivered mismatch: expected %0b, actual %0b",
                       exp_res.delivered, delivered);
                error_count++;
            end
            if (in_range !== exp_res.in_range) begin
                $error("in_range mismatch: expected %0b, actual %0b",
                       exp_res.in_range, in_range);
                error_count++;
            end
        endfunction
    endclass

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx   = CFG_LONG_DELAY;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_func      = FUNC_SET;
    logic [ID_W-1:0]       i_event_id  = '0;
    logic [TIME_W-1:0]     i_now_time  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic                  o_delivered;
    logic                  o_in_range;

    event_flag_tracker flags = new();
    logic [TIME_W-1:0] tick_now;
    int                quiet_cycles = 0;

    t_stall_mode stall_mode   = STALL_NONE;
    int          mode_left    = 0;
    int          stall_period = 1;
    int          stall_on     = 0;
    int          stall_phase  = 0;

    delayed_event_flag_table_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_func      (i_func),
        .i_event_id  (i_event_id),
        .i_now_time  (i_now_time),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_delivered (o_delivered),
        .o_in_range  (o_in_range)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Receiver stall pattern; the style is picked anew at random whenever its run ends.
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode   = t_stall_mode'($urandom_range(0, 3));
            mode_left    = $urandom_range(50, 300);
            stall_period = $urandom_range(4, 12);
            stall_on     = $urandom_range(1, stall_period / 2);
            stall_phase  = 0;
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:  i_out_stall <= 1'b0;
            STALL_LIGHT: i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: i_out_stall <= ($urandom_range(0, 1) == 1);
            default: begin
                i_out_stall <= (stall_phase < stall_on);
                stall_phase = (stall_phase + 1) % stall_period;
            end
        endcase
    end

    // Transfers are observed at the rising edge; the watchdog counts quiet cycles.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                flags.note_op(t_func'(i_func), i_event_id, i_now_time);
            if (o_out_valid && !i_out_stall)
                flags.check_outcome(o_delivered, o_in_range);
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("** delayed_event_flag_table_unit: FAILED **");
            $finish;
        end
    end

    // Called just after a falling edge; returns at the falling edge after the transfer.
    task automatic send_op(t_func f, logic [ID_W-1:0] id, logic [TIME_W-1:0] now);
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_event_id <= id;
        i_now_time <= now;
        do @(posedge i_clk); while (o_in_stall);
        @(negedge i_clk);
    endtask

    // Lets every owed result come back, then lets the bench settle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (flags.outcome_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(t_cfg_reg idx, logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        flags.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic set_config(logic [TIME_W-1:0] long_d, logic [TIME_W-1:0] short_d,
                              int short_s, int nodly_s);
        cfg_write(CFG_LONG_DELAY, long_d);
        cfg_write(CFG_SHORT_DELAY, short_d);
        cfg_write(CFG_SHORT_START, CFG_DATA_W'(short_s));
        cfg_write(CFG_NODLY_START, CFG_DATA_W'(nodly_s));
        i_cfg_we <= 1'b0;
        repeat (2) @(negedge i_clk);
    endtask

    // Random traffic aimed at eight events, some near the current boundaries,
    // so sets, delayed sets and gets keep meeting on the same entries.
    task automatic random_items(int count, bit gappy);
        int              burst_left;
        int              w;
        int              cand;
        t_func           f;
        logic [ID_W-1:0] id;
        logic [TIME_W-1:0] now;
        logic [ID_W-1:0] hot_ids [8];
        for (int k = 0; k < 8; k++) begin
            case (k)
                0: cand = int'(flags.short_start) - 1;
                1: cand = int'(flags.short_start);
                2: cand = int'(flags.nodly_start) - 1;
                3: cand = int'(flags.nodly_start);
                4: cand = 0;
                5: cand = EVENT_COUNT - 1;
                default: cand = $urandom_range(0, EVENT_COUNT - 1);
            endcase
            if (cand < 0 || cand >= EVENT_COUNT)
                cand = $urandom_range(0, EVENT_COUNT - 1);
            hot_ids[k] = ID_W'(cand);
        end
        burst_left = $urandom_range(1, 24);
        for (int n = 0; n < count; n++) begin
            w  = $urandom_range(0, 99);
            id = hot_ids[$urandom_range(0, 7)];
            if (w < 5) begin
                f  = t_func'($urandom_range(0, 3));
                id = ($urandom_range(0, 3) == 0) ? '1 : ID_W'($urandom_range(EVENT_COUNT, 65535));
            end else if (w < 25)
                f = FUNC_SET;
            else if (w < 35)
                f = FUNC_CLEAR;
            else if (w < 50)
                f = FUNC_DSET;
            else
                f = FUNC_GET;
            if ($urandom_range(0, 9) == 0)
                tick_now += $urandom_range(0, 1000);
            else
                tick_now += $urandom_range(0, 50);
            now = ($urandom_range(0, 19) == 0) ? TIME_W'($urandom) : tick_now;
            send_op(f, id, now);
            burst_left--;
            if (burst_left == 0) begin
                if (gappy) begin
                    i_in_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(negedge i_clk);
                end
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    initial begin
        tick_now = $urandom;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part under the reset settings.
        send_op(FUNC_GET, 0, 0);
        send_op(FUNC_SET, 255, '0);
        send_op(FUNC_GET, 255, '1);
        // Out-of-range events leave the table and the stamp alone.
        send_op(FUNC_DSET, 256, 32'hDEAD_BEEF);
        send_op(FUNC_DSET, 16'hFFFF, 32'h1234_5678);
        send_op(FUNC_GET, 16'hFFFF, 0);
        // A clear keeps the holdoff mark; the get of a marked idle event does nothing.
        send_op(FUNC_DSET, 5, 100);
        send_op(FUNC_CLEAR, 5, 0);
        send_op(FUNC_GET, 5, 32'h8000_0000);
        send_op(FUNC_SET, 5, 0);
        send_op(FUNC_GET, 5, 100 + 60000);
        send_op(FUNC_GET, 5, 100 + 60001);
        // Short delay with the elapsed time wrapping past zero.
        send_op(FUNC_DSET, 64, 32'hFFFF_FF00);
        send_op(FUNC_GET, 64, 32'hFFFF_FF00 + 10000);
        send_op(FUNC_GET, 64, 32'hFFFF_FF00 + 10001);
        send_op(FUNC_DSET, 128, 7);
        send_op(FUNC_GET, 128, 7);
        send_op(FUNC_DSET, 127, '1);
        send_op(FUNC_GET, 127, 0);
        send_op(FUNC_DSET, 63, 50);
        send_op(FUNC_GET, 63, 50 + 60001);
        send_op(FUNC_DSET, 100, 60);
        drain();

        // All boundaries at zero: the marks left on 100 and 127 no longer hold them back.
        set_config('0, '0, 0, 0);
        send_op(FUNC_GET, 100, 61);
        send_op(FUNC_GET, 127, 61);
        random_items(200, 1'b1);
        drain();

        // Largest delays: a marked event can never become ready.
        set_config('1, '1, 256, 256);
        random_items(200, 1'b0);
        drain();

        // Boundaries out of order.
        set_config(40, 200, 200, 100);
        random_items(250, 1'b1);
        drain();

        set_config(300, 30, 255, 256);
        random_items(250, 1'b1);
        drain();

        for (int p = 0; p < 4; p++) begin
            set_config($urandom_range(0, 400), $urandom_range(0, 400),
                       $urandom_range(0, 256), $urandom_range(0, 256));
            random_items(250, p[0]);
            drain();
        end

        if (flags.error_count == 0)
            $display("** delayed_event_flag_table_unit: PASSED **");
        else
            $display("** delayed_event_flag_table_unit: FAILED **");
        $finish;
    end

endmodule

// File: delayed_event_flag_table_unit.f
rtl/core/defet_pkg.sv
rtl/core/defet_cfg_regs.sv
rtl/core/defet_flag_table.sv
rtl/core/delayed_event_flag_table_unit.sv
sim/delayed_event_flag_table_unit_tb.sv
